// ----- rtl/core/qrf_pkg.sv -----
`default_nettype none

package qrf_pkg;

  // Symbol geometry
  localparam int MAX_VERSION = 40;
  localparam int SIDE_STEP   = 4;
  localparam int SIDE_BASE   = 17;
  localparam int NEAR_LIMIT  = 10;
  localparam int FINDER_SPAN = 7;
  localparam int SEP_OFFSET  = 8;
  localparam int TIMING_LINE = 6;
  localparam int ALIGN_SLOTS = 7;
  localparam int VER_W       = 6;
  localparam int COORD_W     = 8;
  localparam int VIDX_W      = $clog2(MAX_VERSION);

  typedef logic [COORD_W-1:0] coord_t;
  typedef logic [0:ALIGN_SLOTS-1][COORD_W-1:0] pos_row_t;
  typedef logic [0:ALIGN_SLOTS-1] slot_mask_t;

  // Alignment center positions, one row per version, unused slots zero
  localparam pos_row_t ALIGN_POS [0:MAX_VERSION-1] = '{
    '{8'd0,  8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0},
    '{8'd6,  8'd18,  8'd0,   8'd0,   8'd0,   8'd0,   8'd0},
    '{8'd6,  8'd22,  8'd0,   8'd0,   8'd0,   8'd0,   8'd0},
    '{8'd6,  8'd26,  8'd0,   8'd0,   8'd0,   8'd0,   8'd0},
    '{8'd6,  8'd30,  8'd0,   8'd0,   8'd0,   8'd0,   8'd0},
    '{8'd6,  8'd34,  8'd0,   8'd0,   8'd0,   8'd0,   8'd0},
    '{8'd6,  8'd22,  8'd38,  8'd0,   8'd0,   8'd0,   8'd0},
    '{8'd6,  8'd24,  8'd42,  8'd0,   8'd0,   8'd0,   8'd0},
    '{8'd6,  8'd26,  8'd46,  8'd0,   8'd0,   8'd0,   8'd0},
    '{8'd6,  8'd28,  8'd50,  8'd0,   8'd0,   8'd0,   8'd0},
    '{8'd6,  8'd30,  8'd54,  8'd0,   8'd0,   8'd0,   8'd0},
    '{8'd6,  8'd32,  8'd58,  8'd0,   8'd0,   8'd0,   8'd0},
    '{8'd6,  8'd34,  8'd62,  8'd0,   8'd0,   8'd0,   8'd0},
    '{8'd6,  8'd26,  8'd46,  8'd66,  8'd0,   8'd0,   8'd0},
    '{8'd6,  8'd26,  8'd48,  8'd70,  8'd0,   8'd0,   8'd0},
    '{8'd6,  8'd26,  8'd50,  8'd74,  8'd0,   8'd0,   8'd0},
    '{8'd6,  8'd30,  8'd54,  8'd78,  8'd0,   8'd0,   8'd0},
    '{8'd6,  8'd30,  8'd56,  8'd82,  8'd0,   8'd0,   8'd0},
    '{8'd6,  8'd30,  8'd58,  8'd86,  8'd0,   8'd0,   8'd0},
    '{8'd6,  8'd34,  8'd62,  8'd90,  8'd0,   8'd0,   8'd0},
    '{8'd6,  8'd28,  8'd50,  8'd72,  8'd94,  8'd0,   8'd0},
    '{8'd6,  8'd26,  8'd50,  8'd74,  8'd98,  8'd0,   8'd0},
    '{8'd6,  8'd30,  8'd54,  8'd78,  8'd102, 8'd0,   8'd0},
    '{8'd6,  8'd28,  8'd54,  8'd80,  8'd106, 8'd0,   8'd0},
    '{8'd6,  8'd32,  8'd58,  8'd84,  8'd110, 8'd0,   8'd0},
    '{8'd6,  8'd30,  8'd58,  8'd86,  8'd114, 8'd0,   8'd0},
    '{8'd6,  8'd34,  8'd62,  8'd90,  8'd118, 8'd0,   8'd0},
    '{8'd6,  8'd26,  8'd50,  8'd74,  8'd98,  8'd122, 8'd0},
    '{8'd6,  8'd30,  8'd54,  8'd78,  8'd102, 8'd126, 8'd0},
    '{8'd6,  8'd26,  8'd52,  8'd78,  8'd104, 8'd130, 8'd0},
    '{8'd6,  8'd30,  8'd56,  8'd82,  8'd108, 8'd134, 8'd0},
    '{8'd6,  8'd34,  8'd60,  8'd86,  8'd112, 8'd138, 8'd0},
    '{8'd6,  8'd30,  8'd58,  8'd86,  8'd114, 8'd142, 8'd0},
    '{8'd6,  8'd34,  8'd62,  8'd90,  8'd118, 8'd146, 8'd0},
    '{8'd6,  8'd30,  8'd54,  8'd78,  8'd102, 8'd126, 8'd150},
    '{8'd6,  8'd24,  8'd50,  8'd76,  8'd102, 8'd128, 8'd154},
    '{8'd6,  8'd28,  8'd54,  8'd80,  8'd106, 8'd132, 8'd158},
    '{8'd6,  8'd32,  8'd58,  8'd84,  8'd110, 8'd136, 8'd162},
    '{8'd6,  8'd26,  8'd54,  8'd82,  8'd110, 8'd138, 8'd166},
    '{8'd6,  8'd30,  8'd58,  8'd86,  8'd114, 8'd142, 8'd170}
  };

  // Stage 1 -> stage 2 payload
  typedef struct packed {
    coord_t     col;
    coord_t     row;
    coord_t     side;
    pos_row_t   pos;
    slot_mask_t slot_en;
  } qrf_fetch_t;

  // Stage 2 -> stage 3 match flags
  typedef struct packed {
    logic       in_range;
    logic       dark_mod;
    logic       trow_hit;
    logic       trow_dark;
    logic       tcol_hit;
    logic       tcol_dark;
    logic       ax_hit;
    logic       ax_small;
    logic       ax_big;
    logic [1:0] ax_dist;
    logic       ay_hit;
    logic       ay_small;
    logic       ay_big;
    logic [1:0] ay_dist;
    logic       sep_hit;
    logic       fnd_hit;
    logic       fnd_dark;
  } qrf_flags_t;

  // Number of alignment centers per axis: none for version 1, else ver/7 + 2
  function automatic slot_mask_t align_mask(logic [VER_W-1:0] ver);
    slot_mask_t m;
    m = '0;
    if (ver <= 6'd1) begin
      m = '0;
    end else if (ver < 6'd7) begin
      m = 7'b1100000;
    end else if (ver < 6'd14) begin
      m = 7'b1110000;
    end else if (ver < 6'd21) begin
      m = 7'b1111000;
    end else if (ver < 6'd28) begin
      m = 7'b1111100;
    end else if (ver < 6'd35) begin
      m = 7'b1111110;
    end else begin
      m = 7'b1111111;
    end
    return m;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/qr_function_pattern_module_top.sv -----
// QR function pattern lookup.
// Input channel (in_valid_i/in_ready_o) carries one module coordinate per
// item: module_column_i (x) and module_row_i (y). Output channel
// (out_valid_o/out_ready_i) returns one item per input, in order:
// is_function_o is set when a finder, separator, alignment, timing or dark
// module covers the coordinate, module_dark_o gives its color (0 otherwise).
// cfg_we_i writes the symbol version from cfg_wdata_i; 0 is taken as 1 and
// values above 40 as 40. Write it only while no items are in flight.
// Three register stages (fetch, match, resolve); an accepted item moves
// through them in order to out_valid_o. Throughput: one item per cycle,
// each stage takes a new item whenever the stage after it moves on.
// Reset clears all stage valid bits and sets the version to 1.
// When out_ready_i is low, the result holds and the stages behind it keep
// filling; in_ready_o drops once all three stages are occupied. No item is
// dropped or repeated.
`default_nettype none

module qr_function_pattern_module_top import qrf_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [COORD_W-1:0] module_column_i,
  input  wire logic [COORD_W-1:0] module_row_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic                    is_function_o,
  output logic                    module_dark_o,
  input  wire logic               cfg_we_i,
  input  wire logic [VER_W-1:0]   cfg_wdata_i
);

  logic [VER_W-1:0] version_q, version_d;
  coord_t           side_q, side_d;

  logic       s1_valid, s1_ready, s2_valid, s2_ready;
  qrf_fetch_t s1_data;
  qrf_flags_t s2_flags;

  // Clamp the version on write and precompute the symbol side
  always_comb begin
    version_d = cfg_wdata_i;
    if (cfg_wdata_i == '0) begin
      version_d = VER_W'(1);
    end else if (cfg_wdata_i > VER_W'(MAX_VERSION)) begin
      version_d = VER_W'(MAX_VERSION);
    end
    side_d = COORD_W'({version_d, 2'b00}) + COORD_W'(SIDE_BASE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      version_q <= VER_W'(1);
      side_q    <= COORD_W'(SIDE_STEP + SIDE_BASE);
    end else if (cfg_we_i) begin
      version_q <= version_d;
      side_q    <= side_d;
    end
  end

  qrf_fetch u_fetch (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (in_valid_i),
    .ready_o   (in_ready_o),
    .col_i     (module_column_i),
    .row_i     (module_row_i),
    .side_i    (side_q),
    .version_i (version_q),
    .valid_o   (s1_valid),
    .ready_i   (s1_ready),
    .data_o    (s1_data)
  );

  qrf_match u_match (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s1_valid),
    .ready_o (s1_ready),
    .data_i  (s1_data),
    .valid_o (s2_valid),
    .ready_i (s2_ready),
    .flags_o (s2_flags)
  );

  qrf_resolve u_resolve (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (s2_valid),
    .ready_o       (s2_ready),
    .flags_i       (s2_flags),
    .valid_o       (out_valid_o),
    .ready_i       (out_ready_i),
    .is_function_o (is_function_o),
    .module_dark_o (module_dark_o)
  );

endmodule

`default_nettype wire

// ----- rtl/core/qrf_fetch.sv -----
`default_nettype none

module qrf_fetch import qrf_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             valid_i,
  output logic                  ready_o,
  input  wire coord_t           col_i,
  input  wire coord_t           row_i,
  input  wire coord_t           side_i,
  input  wire logic [VER_W-1:0] version_i,
  output logic                  valid_o,
  input  wire logic             ready_i,
  output qrf_fetch_t            data_o
);

  logic       valid_q;
  qrf_fetch_t data_q, data_d;
  logic [VIDX_W-1:0] vidx;

  assign ready_o = !valid_q || ready_i;
  assign vidx    = VIDX_W'(version_i - 6'd1);

  // Latch coordinates with the version's alignment row
  always_comb begin
    data_d.col     = col_i;
    data_d.row     = row_i;
    data_d.side    = side_i;
    data_d.pos     = ALIGN_POS[vidx];
    data_d.slot_en = align_mask(version_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

`default_nettype wire

// ----- rtl/core/qrf_match.sv -----
`default_nettype none

module qrf_match import qrf_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       valid_i,
  output logic            ready_o,
  input  wire qrf_fetch_t data_i,
  output logic            valid_o,
  input  wire logic       ready_i,
  output qrf_flags_t      flags_o
);

  logic       valid_q;
  qrf_flags_t flags_q, flags_d;

  coord_t side_m7, side_m8, side_m10;
  coord_t ax_pos, ay_pos;
  logic [COORD_W:0] diff, mag;
  logic [2:0] fdx, fdy, rx, ry, rmax;

  assign ready_o  = !valid_q || ready_i;
  assign side_m7  = data_i.side - COORD_W'(FINDER_SPAN);
  assign side_m8  = data_i.side - COORD_W'(SEP_OFFSET);
  assign side_m10 = data_i.side - COORD_W'(NEAR_LIMIT);

  always_comb begin
    // Alignment: find the center within two modules on each axis
    flags_d.ax_hit  = 1'b0;
    flags_d.ax_dist = '0;
    flags_d.ay_hit  = 1'b0;
    flags_d.ay_dist = '0;
    ax_pos = '0;
    ay_pos = '0;
    diff   = '0;
    mag    = '0;
    for (int i = 0; i < ALIGN_SLOTS; i++) begin
      diff = {1'b0, data_i.col} - {1'b0, data_i.pos[i]};
      mag  = diff[COORD_W] ? (~diff + 9'd1) : diff;
      if (data_i.slot_en[i] && mag <= 9'd2) begin
        flags_d.ax_hit  = 1'b1;
        flags_d.ax_dist = mag[1:0];
        ax_pos          = data_i.pos[i];
      end
      diff = {1'b0, data_i.row} - {1'b0, data_i.pos[i]};
      mag  = diff[COORD_W] ? (~diff + 9'd1) : diff;
      if (data_i.slot_en[i] && mag <= 9'd2) begin
        flags_d.ay_hit  = 1'b1;
        flags_d.ay_dist = mag[1:0];
        ay_pos          = data_i.pos[i];
      end
    end
    flags_d.ax_small = ax_pos < COORD_W'(NEAR_LIMIT);
    flags_d.ax_big   = ax_pos > side_m10;
    flags_d.ay_small = ay_pos < COORD_W'(NEAR_LIMIT);
    flags_d.ay_big   = ay_pos > side_m10;

    // Dark module, timing lines and separators
    flags_d.in_range  = (data_i.col < data_i.side) && (data_i.row < data_i.side);
    flags_d.dark_mod  = (data_i.col == COORD_W'(SEP_OFFSET)) && (data_i.row == side_m8);
    flags_d.trow_hit  = (data_i.row == COORD_W'(TIMING_LINE)) &&
                        (data_i.col >= COORD_W'(SEP_OFFSET)) && (data_i.col < side_m8);
    flags_d.trow_dark = !data_i.col[0];
    flags_d.tcol_hit  = (data_i.col == COORD_W'(TIMING_LINE)) &&
                        (data_i.row >= COORD_W'(SEP_OFFSET)) && (data_i.row < side_m8);
    flags_d.tcol_dark = !data_i.row[0];
    flags_d.sep_hit   =
      ((data_i.row == COORD_W'(FINDER_SPAN)) && (data_i.col <= COORD_W'(FINDER_SPAN))) ||
      ((data_i.col == COORD_W'(FINDER_SPAN)) && (data_i.row <= COORD_W'(FINDER_SPAN))) ||
      ((data_i.col == side_m8) && (data_i.row <= COORD_W'(FINDER_SPAN))) ||
      ((data_i.row == COORD_W'(FINDER_SPAN)) && (data_i.col >= side_m8)) ||
      ((data_i.row == side_m8) && (data_i.col <= COORD_W'(FINDER_SPAN))) ||
      ((data_i.col == COORD_W'(FINDER_SPAN)) && (data_i.row >= side_m8));

    // Finder patterns: offset inside the 7x7 square, then ring distance
    flags_d.fnd_hit = 1'b0;
    fdx = '0;
    fdy = '0;
    if (data_i.col < COORD_W'(FINDER_SPAN) && data_i.row < COORD_W'(FINDER_SPAN)) begin
      flags_d.fnd_hit = 1'b1;
      fdx = data_i.col[2:0];
      fdy = data_i.row[2:0];
    end else if (data_i.col >= side_m7 && data_i.row < COORD_W'(FINDER_SPAN)) begin
      flags_d.fnd_hit = 1'b1;
      fdx = 3'(data_i.col - side_m7);
      fdy = data_i.row[2:0];
    end else if (data_i.col < COORD_W'(FINDER_SPAN) && data_i.row >= side_m7) begin
      flags_d.fnd_hit = 1'b1;
      fdx = data_i.col[2:0];
      fdy = 3'(data_i.row - side_m7);
    end
    rx   = (fdx >= 3'd3) ? (fdx - 3'd3) : (3'd3 - fdx);
    ry   = (fdy >= 3'd3) ? (fdy - 3'd3) : (3'd3 - fdy);
    rmax = (rx > ry) ? rx : ry;
    flags_d.fnd_dark = (rmax != 3'd2);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      flags_q <= flags_d;
    end
  end

  assign valid_o = valid_q;
  assign flags_o = flags_q;

endmodule

`default_nettype wire

// ----- rtl/core/qrf_resolve.sv -----
`default_nettype none

module qrf_resolve import qrf_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       valid_i,
  output logic            ready_o,
  input  wire qrf_flags_t flags_i,
  output logic            valid_o,
  input  wire logic       ready_i,
  output logic            is_function_o,
  output logic            module_dark_o
);

  logic valid_q;
  logic func_q, func_d;
  logic dark_q, dark_d;
  logic skip, al_hit, al_dark;

  assign ready_o = !valid_q || ready_i;

  // Alignment centers next to a finder are left out
  assign skip = (flags_i.ax_small && flags_i.ay_small) ||
                (flags_i.ax_big   && flags_i.ay_small) ||
                (flags_i.ax_small && flags_i.ay_big);
  assign al_hit  = flags_i.ax_hit && flags_i.ay_hit && !skip;
  // light only on the ring at Chebyshev distance one
  assign al_dark = !((flags_i.ax_dist <= 2'd1) && (flags_i.ay_dist <= 2'd1) &&
                     !((flags_i.ax_dist == 2'd0) && (flags_i.ay_dist == 2'd0)));

  // Later drawing wins: dark module, timing, alignment, separator, finder
  always_comb begin
    func_d = 1'b0;
    dark_d = 1'b0;
    if (!flags_i.in_range) begin
      func_d = 1'b0;
      dark_d = 1'b0;
    end else if (flags_i.dark_mod) begin
      func_d = 1'b1;
      dark_d = 1'b1;
    end else if (flags_i.trow_hit) begin
      func_d = 1'b1;
      dark_d = flags_i.trow_dark;
    end else if (flags_i.tcol_hit) begin
      func_d = 1'b1;
      dark_d = flags_i.tcol_dark;
    end else if (al_hit) begin
      func_d = 1'b1;
      dark_d = al_dark;
    end else if (flags_i.sep_hit) begin
      func_d = 1'b1;
      dark_d = 1'b0;
    end else if (flags_i.fnd_hit) begin
      func_d = 1'b1;
      dark_d = flags_i.fnd_dark;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      func_q <= func_d;
      dark_q <= dark_d;
    end
  end

  assign valid_o       = valid_q;
  assign is_function_o = func_q;
  assign module_dark_o = dark_q;

endmodule

`default_nettype wire

// ----- rtl/core/qrf_checker.sv -----
`default_nettype none

module qrf_checker import qrf_pkg::*; (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_valid_i,
  input wire logic               in_ready_o,
  input wire logic [COORD_W-1:0] module_column_i,
  input wire logic [COORD_W-1:0] module_row_i,
  input wire logic               out_valid_o,
  input wire logic               out_ready_i,
  input wire logic               is_function_o,
  input wire logic               module_dark_o
);

  // Nothing is reported while reset holds
  a_reset_empty: assert property (@(posedge clk_i) !rst_ni |-> !out_valid_o)
    else $error("output valid during reset");

  // A module outside any function pattern is never dark
  a_dark_needs_func: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !is_function_o) |-> !module_dark_o)
    else $error("dark result without function pattern");

  // Open receiver means the pipe never back-pressures
  a_no_bubble: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ready_i |-> in_ready_o)
    else $error("input stalled while output is ready");

  // Stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=>
      (out_valid_o && $stable(is_function_o) && $stable(module_dark_o)))
    else $error("stalled result changed");

  // A waiting input item keeps its coordinate
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_ready_o) |=>
      (in_valid_i && $stable(module_column_i) && $stable(module_row_i)))
    else $error("waiting input item changed");

endmodule

bind qr_function_pattern_module_top qrf_checker u_qrf_checker (.*);

`default_nettype wire

// ----- test/qr_function_pattern_module_checker.sv -----
module qr_function_pattern_module_checker import qrf_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic [COORD_W-1:0] module_column_i,
  input  logic [COORD_W-1:0] module_row_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic               is_function_i,
  input  logic               module_dark_i,
  input  logic               cfg_we_i,
  input  logic [VER_W-1:0]   cfg_wdata_i,
  output int                 fail_count_o,
  output int                 pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    coord_t col;
    coord_t row;
    logic   is_function;
    logic   dark;
  } module_verdict_t;

  module_verdict_t  expected_modules[$];
  module_verdict_t  want;
  logic [VER_W-1:0] symbol_ver;

  // Which pattern, if any, the drawing leaves on (x, y); later layers win
  function automatic module_verdict_t draw_function_module(logic [VER_W-1:0] ver_code,
                                                           int x, int y);
    module_verdict_t res;
    int ver, side, s, n, step, i, j, cx, cy, dx, dy, ox, oy;
    int centers [0:ALIGN_SLOTS-1];
    logic hit, dark;
    res.col = x[COORD_W-1:0];
    res.row = y[COORD_W-1:0];
    hit = 1'b0;
    dark = 1'b0;
    ver = int'(ver_code);
    if (ver < 1) ver = 1;
    if (ver > MAX_VERSION) ver = MAX_VERSION;
    side = ver * SIDE_STEP + SIDE_BASE;
    s = side - SEP_OFFSET;

    // alignment centers: first at 6, the rest evenly back from side-7
    n = (ver == 1) ? 0 : ver / 7 + 2;
    if (n > ALIGN_SLOTS) n = ALIGN_SLOTS;
    for (i = 0; i < ALIGN_SLOTS; i++) centers[i] = 0;
    if (n > 0) begin
      step = (ver == 32) ? 26 : ((ver * 4 + n * 2 + 1) / (n * 2 - 2)) * 2;
      centers[0] = 6;
      for (i = 1; i < n; i++) centers[n - i] = side - 7 - (i - 1) * step;
    end

    if (x >= side || y >= side) begin
      hit = 1'b0;
    end else if (x == 8 && y == s) begin
      hit = 1'b1;
      dark = 1'b1;
    end else if (y == TIMING_LINE && x >= 8 && x < s) begin
      hit = 1'b1;
      dark = (x % 2) == 0;
    end else if (x == TIMING_LINE && y >= 8 && y < s) begin
      hit = 1'b1;
      dark = (y % 2) == 0;
    end else begin
      for (i = 0; i < n; i++) begin
        for (j = 0; j < n; j++) begin
          cx = centers[i];
          cy = centers[j];
          dx = (x > cx) ? x - cx : cx - x;
          dy = (y > cy) ? y - cy : cy - y;
          // no alignment pattern on top of a finder
          if (!((cx < NEAR_LIMIT && cy < NEAR_LIMIT) ||
                (cx > side - NEAR_LIMIT && cy < NEAR_LIMIT) ||
                (cx < NEAR_LIMIT && cy > side - NEAR_LIMIT)) &&
              dx <= 2 && dy <= 2) begin
            hit = 1'b1;
            dark = ((dx > dy) ? dx : dy) != 1;
          end
        end
      end
      if (!hit) begin
        if ((y == 7 && x <= 7) || (x == 7 && y <= 7) || (x == s && y <= 7) ||
            (y == 7 && x >= s) || (y == s && x <= 7) || (x == 7 && y >= s)) begin
          hit = 1'b1;
          dark = 1'b0;
        end else begin
          ox = -1;
          oy = 0;
          if (x < FINDER_SPAN && y < FINDER_SPAN) begin
            ox = 0;
          end else if (x >= side - FINDER_SPAN && y < FINDER_SPAN) begin
            ox = side - FINDER_SPAN;
          end else if (x < FINDER_SPAN && y >= side - FINDER_SPAN) begin
            ox = 0;
            oy = side - FINDER_SPAN;
          end
          if (ox >= 0) begin
            dx = x - ox - 3;
            dy = y - oy - 3;
            if (dx < 0) dx = -dx;
            if (dy < 0) dy = -dy;
            hit = 1'b1;
            // only the ring at distance 2 is light
            dark = ((dx > dy) ? dx : dy) != 2;
          end
        end
      end
    end
    res.is_function = hit;
    res.dark = hit & dark;
    return res;
  endfunction

  // Track version writes, predict on input items, compare output items
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      symbol_ver = 6'd1;
      expected_modules.delete();
      pending_o = 0;
      fail_count_o = 0;
    end else begin
      if (cfg_we_i) symbol_ver = cfg_wdata_i;
      if (out_valid_i && out_ready_i) begin
        if (expected_modules.size() == 0) begin
          $error("unexpected result item: is_function %0b module_dark %0b",
                 is_function_i, module_dark_i);
          fail_count_o++;
        end else begin
          want = expected_modules.pop_front();
          if (is_function_i !== want.is_function) begin
            $error("is_function at (%0d,%0d): expected %0b actual %0b",
                   want.col, want.row, want.is_function, is_function_i);
            fail_count_o++;
          end
          if (module_dark_i !== want.dark) begin
            $error("module_dark at (%0d,%0d): expected %0b actual %0b",
                   want.col, want.row, want.dark, module_dark_i);
            fail_count_o++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        expected_modules.push_back(draw_function_module(symbol_ver,
                                                        int'(module_column_i),
                                                        int'(module_row_i)));
      end
      pending_o = expected_modules.size();
    end
  end

endmodule

// ----- test/qr_function_pattern_module_top_tb.sv -----
module qr_function_pattern_module_top_tb import qrf_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  logic [COORD_W-1:0] module_column_i;
  logic [COORD_W-1:0] module_row_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic               is_function_o;
  logic               module_dark_o;
  logic               cfg_we_i;
  logic [VER_W-1:0]   cfg_wdata_i;

  int               fail_count;
  int               pending;
  logic             calm = 1'b0;
  logic             hold_req = 1'b0;
  logic             hold_done = 1'b0;
  logic [VER_W-1:0] ver_now = 6'd1;

  qr_function_pattern_module_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .module_column_i (module_column_i),
    .module_row_i    (module_row_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .is_function_o   (is_function_o),
    .module_dark_o   (module_dark_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i)
  );

  qr_function_pattern_module_checker pattern_check (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_i      (in_ready_o),
    .module_column_i (module_column_i),
    .module_row_i    (module_row_i),
    .out_valid_i     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .is_function_i   (is_function_o),
    .module_dark_i   (module_dark_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .fail_count_o    (fail_count),
    .pending_o       (pending)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog
  initial begin
    #3ms;
    $display("FAIL");
    $finish;
  end

  // Result side: random stall bursts, one long hold-off on request
  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (calm) begin
        out_ready_i <= 1'b1;
      end else if (hold_req && !hold_done) begin
        out_ready_i <= 1'b0;
        repeat (60) @(negedge clk_i);
        hold_done = 1'b1;
      end else if ($urandom_range(0, 5) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(0, 17)) @(negedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
        repeat ($urandom_range(0, 39)) @(negedge clk_i);
      end
    end
  end

  // Offer one coordinate, with an occasional gap before it
  task automatic send_module(input int x, input int y);
    if (!calm && $urandom_range(0, 9) == 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat ($urandom_range(0, 17)) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    module_column_i <= x[COORD_W-1:0];
    module_row_i <= y[COORD_W-1:0];
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (3) @(negedge clk_i);
  endtask

  task automatic set_version(input logic [VER_W-1:0] v);
    wait_drained();
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    ver_now = v;
  endtask

  // Random coordinates aimed at the pattern areas, plus raster runs
  task automatic stream_modules(input int n_items);
    int sent, ver, side, mode, x, y, run_len, corner;
    ver = ver_now;
    if (ver < 1) ver = 1;
    if (ver > MAX_VERSION) ver = MAX_VERSION;
    side = ver * SIDE_STEP + SIDE_BASE;
    sent = 0;
    while (sent < n_items) begin
      mode = $urandom_range(0, 9);
      if (mode >= 8) begin
        x = $urandom_range(0, side - 1);
        y = $urandom_range(0, side - 1);
        run_len = $urandom_range(8, 24);
        repeat (run_len) begin
          send_module(x, y);
          if (x < 255) x++;
          sent++;
        end
      end else begin
        case (mode)
          0: begin
            x = $urandom_range(0, 255);
            y = $urandom_range(0, 255);
          end
          4, 5: begin
            corner = $urandom_range(0, 2);
            x = ((corner == 1) ? side - 9 : 0) + $urandom_range(0, 8);
            y = ((corner == 2) ? side - 9 : 0) + $urandom_range(0, 8);
          end
          6: begin
            x = $urandom_range(0, side - 1);
            y = TIMING_LINE;
            if ($urandom_range(0, 1)) begin
              y = x;
              x = TIMING_LINE;
            end
          end
          7: begin
            x = $urandom_range(side - 2, side + 1);
            y = $urandom_range(0, side + 1);
            if ($urandom_range(0, 1)) begin
              corner = x;
              x = y;
              y = corner;
            end
          end
          default: begin
            x = $urandom_range(0, side - 1);
            y = $urandom_range(0, side - 1);
          end
        endcase
        send_module(x, y);
        sent++;
      end
    end
  endtask

  // Stimulus and verdict
  initial begin
    int guard;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    module_column_i = '0;
    module_row_i = '0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // version 1 straight out of reset, side 21
    send_module(0, 0);      // finder outer ring
    send_module(1, 1);      // finder light ring
    send_module(2, 2);      // finder core
    send_module(3, 3);
    send_module(6, 6);      // finder corner next to both timing lines
    send_module(7, 7);      // separator
    send_module(8, 13);     // lone dark module
    send_module(8, 6);      // timing row, even
    send_module(9, 6);      // timing row, odd
    send_module(6, 9);      // timing column, odd
    send_module(6, 12);     // timing column, even
    send_module(13, 0);     // top-right separator
    send_module(14, 0);     // top-right finder
    send_module(0, 14);     // bottom-left finder
    send_module(20, 20);    // plain data module
    send_module(21, 0);     // just outside
    send_module(255, 255);  // far outside
    // version 7: alignment grid with skipped corners
    set_version(6'd7);
    send_module(22, 22);    // alignment center
    send_module(21, 21);    // alignment light ring
    send_module(20, 24);    // alignment outer ring
    send_module(22, 6);     // timing row crosses an alignment pattern
    send_module(22, 4);     // alignment above the timing row
    send_module(38, 4);     // skipped alignment inside top-right finder
    send_module(4, 22);     // alignment beside the timing column
    send_module(5, 21);

    set_version(6'd2);
    stream_modules(55);
    // long result stall while items keep coming
    set_version(6'd40);
    hold_req = 1'b1;
    stream_modules(55);
    set_version(6'd63);     // clamps to the largest version
    stream_modules(55);
    set_version(6'd0);      // treated as version 1
    stream_modules(50);
    set_version(6'd41);
    stream_modules(30);
    wait_drained();
    stream_modules(25);
    set_version(6'd14);
    stream_modules(55);
    set_version(6'd32);     // irregular alignment spacing
    stream_modules(55);
    set_version(6'd21);
    stream_modules(55);
    set_version(6'd35);
    stream_modules(55);
    repeat (2) begin
      set_version(VER_W'($urandom_range(0, 63)));
      stream_modules(55);
    end
    // back-to-back tail
    set_version(6'd27);
    calm = 1'b1;
    stream_modules(60);

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    guard = 0;
    while (pending != 0 && guard < 2000) begin
      @(negedge clk_i);
      guard++;
    end
    repeat (10) @(negedge clk_i);
    if (pending == 0 && fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/qrf_pkg.sv
rtl/core/qrf_fetch.sv
rtl/core/qrf_match.sv
rtl/core/qrf_resolve.sv
rtl/core/qr_function_pattern_module_top.sv
rtl/core/qrf_checker.sv
test/qr_function_pattern_module_checker.sv
test/qr_function_pattern_module_top_tb.sv
